// ===== design/enumeration_rank_sorter_macros.svh =====
// ----------------------------------------------------------------------------
// enumeration_rank_sorter_macros
// assertion macros used by the rank sorter rtl
// ----------------------------------------------------------------------------
`ifndef ENUMERATION_RANK_SORTER_MACROS_SVH
`define ENUMERATION_RANK_SORTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ERS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ers assertion failed");

// next-cycle implication, disabled during reset
`define ERS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ers assertion failed");

`endif

// ===== design/ers_pkg.sv =====
// ----------------------------------------------------------------------------
// ers_pkg
// shared constants of the enumeration rank sorter
// ----------------------------------------------------------------------------
`default_nettype none

package ers_pkg;

    // default store capacity
    localparam int MAX_ENTRIES_DEF = 32;

    // key width of one entry
    localparam int KEY_W = 63;

    // width of the index and rank result fields
    localparam int OUT_W = 5;

endpackage

`default_nettype wire

// ===== design/enumeration_rank_sorter.sv =====
// ----------------------------------------------------------------------------
// enumeration_rank_sorter
// rank sort by enumeration over a chain of key cells
// ----------------------------------------------------------------------------
// usage:
//   in channel  (in_valid/in_ready): one entry_key per beat, last_entry marks
//     the final key of a set. keys are ranked largest first.
//   cfg channel (cfg_valid/cfg_ready): cfg_data is tie_later_first, always
//     ready; write it only while the block is idle.
//   out channel (out_valid/out_ready): after the last entry, one beat per
//     stored entry in load order with entry_index, rank, last_result and
//     overflowed.
// timing:
//   a stored key walks the chain one cell per cycle past the keys already
//   held, so in_ready stays low from its beat until the key lands; a key
//   dropped on a full store does not lower in_ready. results leave at one
//   beat per cycle from the head cell while the receiver is ready, n beats
//   for n stored entries; out_valid rises after the last key lands, the
//   phase turns to output and the first result is registered.
//   a stalled receiver holds the output register; the chain waits, and
//   the next set may be loaded once the final result is registered.
// reset: empty store, no overflow, tie_later_first = 1, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "enumeration_rank_sorter_macros.svh"

module enumeration_rank_sorter
    import ers_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [KEY_W-1:0] entry_key,
    input  wire logic             last_entry,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [OUT_W-1:0]      entry_index,
    output logic [OUT_W-1:0]      rank,
    output logic                  last_result,
    output logic                  overflowed,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_data
);

    localparam int IDXW = $clog2(MAX_ENTRIES);
    localparam int CNTW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MAX_ENTRIES);

    // phase codes
    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_OUT  = 1'b1;

    // control registers
    logic            state_reg,     state_next;
    logic [CNTW-1:0] count_reg,     count_next;
    logic            ovf_reg,       ovf_next;
    logic            busy_reg,      busy_next;      // a key is walking the chain
    logic [CNTW-1:0] hop_reg,       hop_next;       // cell the key sits at
    logic            last_pend_reg, last_pend_next;
    logic            tie_reg,       tie_next;       // tie_later_first
    logic            tie_run_reg,   tie_run_next;   // rule frozen at the last entry
    logic [CNTW-1:0] out_k_reg,     out_k_next;
    logic            out_valid_reg, out_valid_next;
    logic            tok0_valid_reg, tok0_valid_next;

    // payload registers
    logic [KEY_W-1:0] tok0_key_reg;
    logic [OUT_W-1:0] idx_reg;
    logic [OUT_W-1:0] rank_reg;
    logic             lastr_reg;
    logic             ovfo_reg;

    // chain wiring: token moves right, readout shifts left
    logic             tok_valid [0:MAX_ENTRIES];
    logic [KEY_W-1:0] tok_key   [0:MAX_ENTRIES];
    logic [IDXW-1:0]  tok_gt    [0:MAX_ENTRIES];
    logic [IDXW-1:0]  tok_eqe   [0:MAX_ENTRIES];
    logic [IDXW-1:0]  sh_gt     [0:MAX_ENTRIES];
    logic [IDXW-1:0]  sh_eql    [0:MAX_ENTRIES];
    logic [IDXW-1:0]  sh_eqe    [0:MAX_ENTRIES];

    logic            accept;
    logic            full;
    logic            land;
    logic            out_load;
    logic            out_final;
    logic [IDXW-1:0] head_rank;

    assign in_ready  = (state_reg == ST_LOAD) && !busy_reg;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign full      = count_reg == FULL_CNT;
    assign land      = busy_reg && (hop_reg == count_reg);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign out_final = out_k_reg == CNTW'(count_reg - 1'b1);

    // head cell rank: larger keys, earlier and later, plus the ties that win under the rule
    assign head_rank = sh_gt[0] + (tie_run_reg ? sh_eql[0] : sh_eqe[0]);

    // the key enters at cell 0 with no wins counted yet
    assign tok_valid[0] = tok0_valid_reg;
    assign tok_key[0]   = tok0_key_reg;
    assign tok_gt[0]    = '0;
    assign tok_eqe[0]   = '0;

    // nothing shifts in past the tail
    assign sh_gt[MAX_ENTRIES]  = '0;
    assign sh_eql[MAX_ENTRIES] = '0;
    assign sh_eqe[MAX_ENTRIES] = '0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        ers_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .CELL_IDX    (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .count         (count_reg),
            .shift         (out_load),
            .tok_in_valid  (tok_valid[i]),
            .tok_in_key    (tok_key[i]),
            .tok_in_gt     (tok_gt[i]),
            .tok_in_eqe    (tok_eqe[i]),
            .tok_out_valid (tok_valid[i+1]),
            .tok_out_key   (tok_key[i+1]),
            .tok_out_gt    (tok_gt[i+1]),
            .tok_out_eqe   (tok_eqe[i+1]),
            .sh_in_gt      (sh_gt[i+1]),
            .sh_in_eql     (sh_eql[i+1]),
            .sh_in_eqe     (sh_eqe[i+1]),
            .sh_out_gt     (sh_gt[i]),
            .sh_out_eql    (sh_eql[i]),
            .sh_out_eqe    (sh_eqe[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        busy_next       = busy_reg;
        hop_next        = hop_reg;
        last_pend_next  = last_pend_reg;
        tie_next        = tie_reg;
        tie_run_next    = tie_run_reg;
        out_k_next      = out_k_reg;
        tok0_valid_next = 1'b0;
        out_valid_next  = out_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            tie_next = cfg_data;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (last_entry)
                    begin
                        tie_run_next = tie_reg;
                    end
                    if (full)
                    begin
                        // store full: drop the key, flag it
                        ovf_next = 1'b1;
                        if (last_entry)
                        begin
                            state_next = ST_OUT;
                            out_k_next = '0;
                        end
                    end
                    else
                    begin
                        tok0_valid_next = 1'b1;
                        busy_next       = 1'b1;
                        hop_next        = '0;
                        last_pend_next  = last_entry;
                    end
                end
                else if (land)
                begin
                    busy_next  = 1'b0;
                    count_next = count_reg + 1'b1;
                    if (last_pend_reg)
                    begin
                        state_next = ST_OUT;
                        out_k_next = '0;
                    end
                end
                else if (busy_reg)
                begin
                    hop_next = hop_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_k_next = out_k_reg + 1'b1;
                    if (out_final)
                    begin
                        // run done: store empties for the next set
                        state_next = ST_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            busy_reg       <= 1'b0;
            hop_reg        <= '0;
            last_pend_reg  <= 1'b0;
            tie_reg        <= 1'b1;
            tie_run_reg    <= 1'b1;
            out_k_reg      <= '0;
            out_valid_reg  <= 1'b0;
            tok0_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            busy_reg       <= busy_next;
            hop_reg        <= hop_next;
            last_pend_reg  <= last_pend_next;
            tie_reg        <= tie_next;
            tie_run_reg    <= tie_run_next;
            out_k_reg      <= out_k_next;
            out_valid_reg  <= out_valid_next;
            tok0_valid_reg <= tok0_valid_next;
        end
    end

    // key capture and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok0_key_reg <= entry_key;
        end
        if (out_load)
        begin
            idx_reg   <= OUT_W'(out_k_reg);
            rank_reg  <= OUT_W'(head_rank);
            lastr_reg <= out_final;
            ovfo_reg  <= ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = idx_reg;
    assign rank        = rank_reg;
    assign last_result = lastr_reg;
    assign overflowed  = ovfo_reg;

    // checks
    `ERS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `ERS_ASSERT_IMP(a_no_tok_exit, clk, rst_n, 1'b1, !tok_valid[MAX_ENTRIES])
    `ERS_ASSERT_NXT(a_land_count, clk, rst_n, land && !accept, count_reg == $past(count_reg) + 1'b1)
    `ERS_ASSERT_IMP(a_out_idle_chain, clk, rst_n, state_reg == ST_OUT, !busy_reg && !tok0_valid_reg)

endmodule

`default_nettype wire

// ===== design/ers_cell.sv =====
// ----------------------------------------------------------------------------
// ers_cell
// one store slot: holds a key and its win/tie counts, compares a passing key
// ----------------------------------------------------------------------------
`default_nettype none

module ers_cell
    import ers_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int CELL_IDX    = 0,
    localparam int IDXW = $clog2(MAX_ENTRIES),
    localparam int CNTW = $clog2(MAX_ENTRIES + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNTW-1:0]  count,
    input  wire logic             shift,
    input  wire logic             tok_in_valid,
    input  wire logic [KEY_W-1:0] tok_in_key,
    input  wire logic [IDXW-1:0]  tok_in_gt,
    input  wire logic [IDXW-1:0]  tok_in_eqe,
    output logic                  tok_out_valid,
    output logic [KEY_W-1:0]      tok_out_key,
    output logic [IDXW-1:0]       tok_out_gt,
    output logic [IDXW-1:0]       tok_out_eqe,
    input  wire logic [IDXW-1:0]  sh_in_gt,
    input  wire logic [IDXW-1:0]  sh_in_eql,
    input  wire logic [IDXW-1:0]  sh_in_eqe,
    output logic [IDXW-1:0]       sh_out_gt,
    output logic [IDXW-1:0]       sh_out_eql,
    output logic [IDXW-1:0]       sh_out_eqe
);

    localparam logic [CNTW-1:0] MY_IDX = CNTW'(CELL_IDX);

    logic [KEY_W-1:0] key_reg;
    logic [IDXW-1:0]  gt_reg;    // earlier and later keys strictly larger
    logic [IDXW-1:0]  eql_reg;   // later keys equal
    logic [IDXW-1:0]  eqe_reg;   // earlier keys equal
    logic             tok_valid_reg;
    logic [KEY_W-1:0] tok_key_reg;
    logic [IDXW-1:0]  tok_gt_reg;
    logic [IDXW-1:0]  tok_eqe_reg;

    logic occupied;
    logic landing;
    logic passing;
    logic tok_bigger;
    logic tok_equal;
    logic cell_bigger;

    assign occupied    = MY_IDX < count;
    assign landing     = tok_in_valid && (MY_IDX == count);
    assign passing     = tok_in_valid && occupied;
    assign tok_bigger  = tok_in_key > key_reg;
    assign tok_equal   = tok_in_key == key_reg;
    assign cell_bigger = !tok_bigger && !tok_equal;

    // token handoff to the right neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= passing;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_key_reg <= tok_in_key;
        tok_gt_reg  <= tok_in_gt + IDXW'(cell_bigger);
        tok_eqe_reg <= tok_in_eqe + IDXW'(tok_equal);
    end

    // slot contents: land, count wins, or shift left during readout
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            gt_reg  <= sh_in_gt;
            eql_reg <= sh_in_eql;
            eqe_reg <= sh_in_eqe;
        end
        else if (landing)
        begin
            key_reg <= tok_in_key;
            gt_reg  <= tok_in_gt;
            eqe_reg <= tok_in_eqe;
            eql_reg <= '0;
        end
        else if (passing)
        begin
            gt_reg  <= gt_reg + IDXW'(tok_bigger);
            eql_reg <= eql_reg + IDXW'(tok_equal);
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out_key   = tok_key_reg;
    assign tok_out_gt    = tok_gt_reg;
    assign tok_out_eqe   = tok_eqe_reg;
    assign sh_out_gt     = gt_reg;
    assign sh_out_eql    = eql_reg;
    assign sh_out_eqe    = eqe_reg;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the enumeration rank sorter: sets of 63-bit keys
// go in, a local copy of the ranking rules predicts every output beat,
// tie rule switched between sets, random idling on both channels
// ----------------------------------------------------------------------------

import ers_pkg::*;

typedef struct {
    logic [OUT_W-1:0] index;
    logic [OUT_W-1:0] position;
    logic             final_beat;
    logic             dropped;
} rank_beat_t;

// collects the keys of the current set and ranks them when the set closes
class set_ranker;
    int                 capacity;
    bit                 later_wins;
    logic [KEY_W-1:0]   held_keys[$];
    bit                 lost_entry;
    rank_beat_t         pending_ranks[$];
    int                 faults;
    int                 beats_checked;
    int                 sets_ranked;
    int                 sets_over;
    int                 sets_full;
    int                 tie_sets[2];

    function new(int cap);
        capacity   = cap;
        later_wins = 1'b1;
        lost_entry = 1'b0;
        faults     = 0;
        beats_checked = 0;
        sets_ranked = 0;
        sets_over  = 0;
        sets_full  = 0;
        tie_sets   = '{0, 0};
    endfunction

    function void set_tie_rule(bit later);
        later_wins = later;
    endfunction

    function int outstanding();
        return pending_ranks.size();
    endfunction

    // one accepted input beat; a closing entry produces the ranked set
    function void load_entry(logic [KEY_W-1:0] key, logic closes);
        int         wins_against[];
        int         n;
        bit         first_wins;
        rank_beat_t beat;

        if (held_keys.size() < capacity)
            held_keys.push_back(key);
        else
            lost_entry = 1'b1;
        if (!closes)
            return;

        n = held_keys.size();
        wins_against = new[n];
        foreach (wins_against[i])
            wins_against[i] = 0;
        // each pair is decided once; the loser's rank goes up
        for (int a = 0; a < n; a++)
        begin
            for (int b = a + 1; b < n; b++)
            begin
                if (later_wins)
                    first_wins = held_keys[a] > held_keys[b];
                else
                    first_wins = held_keys[a] >= held_keys[b];
                if (first_wins)
                    wins_against[b]++;
                else
                    wins_against[a]++;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            beat.index      = OUT_W'(k);
            beat.position   = OUT_W'(wins_against[k]);
            beat.final_beat = (k == n - 1);
            beat.dropped    = lost_entry;
            pending_ranks.push_back(beat);
        end

        sets_ranked++;
        tie_sets[later_wins]++;
        if (lost_entry)
            sets_over++;
        else if (n == capacity)
            sets_full++;
        held_keys.delete();
        lost_entry = 1'b0;
    endfunction

    function void note_fault();
        faults++;
    endfunction

    // compare one output beat against the oldest predicted beat
    function void check_rank_beat(rank_beat_t got);
        rank_beat_t want;

        beats_checked++;
        if (pending_ranks.size() == 0)
        begin
            faults++;
            if (faults <= 10)
                $display("unexpected beat: idx=%0d rank=%0d last=%0b ovf=%0b",
                         got.index, got.position, got.final_beat, got.dropped);
            return;
        end
        want = pending_ranks.pop_front();
        if (got.index !== want.index || got.position !== want.position ||
            got.final_beat !== want.final_beat || got.dropped !== want.dropped)
        begin
            faults++;
            if (faults <= 10)
            begin
                $write("rank beat mismatch: exp idx=%0d rank=%0d last=%0b ovf=%0b, ",
                       want.index, want.position, want.final_beat, want.dropped);
                $display("got idx=%0d rank=%0d last=%0b ovf=%0b",
                         got.index, got.position, got.final_beat, got.dropped);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int               CAPACITY     = MAX_ENTRIES_DEF;
    localparam int               ITEM_TARGET  = 260;
    localparam int               SETTLE       = 8;     // quiet cycles before a register write
    localparam int               HOLD_CYCLES  = 90;    // long receiver hold-off
    localparam int               STALL_LIMIT  = 3000;  // cycles with no beat on any channel
    localparam logic [KEY_W-1:0] KEY_MAX      = {KEY_W{1'b1}};

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [KEY_W-1:0] entry_key;
    logic             last_entry;
    logic             out_valid;
    logic             out_ready;
    logic [OUT_W-1:0] entry_index;
    logic [OUT_W-1:0] rank;
    logic             last_result;
    logic             overflowed;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_data;

    set_ranker ranks;
    bit        calm;          // no idling on either side while set
    int        hold_asks;     // bumped to request a long receiver hold-off
    int        loaded;        // accepted input beats
    int        quiet_cycles;

    enumeration_rank_sorter #(
        .MAX_ENTRIES (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .entry_key   (entry_key),
        .last_entry  (last_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_index (entry_index),
        .rank        (rank),
        .last_result (last_result),
        .overflowed  (overflowed),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: random stall bursts, plus the long hold-off on request
    initial
    begin
        int hold_left;
        int stall_left;
        int hold_seen;

        hold_left  = 0;
        stall_left = 0;
        hold_seen  = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                // this cycle counts as the first of the burst
                stall_left = $urandom_range(1, 7) - 1;
                out_ready  = 1'b0;
            end
            else
                out_ready = 1'b1;
        end
    end

    // every accepted output beat is checked against the prediction
    always @(posedge clk)
    begin
        rank_beat_t got;

        if (rst_n && out_valid && out_ready)
        begin
            got.index      = entry_index;
            got.position   = rank;
            got.final_beat = last_result;
            got.dropped    = overflowed;
            ranks.check_rank_beat(got);
        end
    end

    // watchdog: ends a run that stops moving beats
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles with no beat", quiet_cycles);
            $display("tb_top: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // random key: extremes, near-extremes, small values for ties, full-width
    function automatic logic [KEY_W-1:0] pick_key(bit tie_heavy);
        logic [63:0] raw;

        raw = {$urandom, $urandom};
        if (tie_heavy)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return KEY_MAX;
                default: return KEY_W'($urandom_range(1, 3));
            endcase
        end
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return KEY_MAX;
            2:       return KEY_W'($urandom_range(0, 15));
            3:       return KEY_MAX - KEY_W'($urandom_range(0, 15));
            default: return raw[KEY_W-1:0];
        endcase
    endfunction

    // mostly short sets, a few long ones, rarely past capacity
    function automatic int pick_set_size();
        int r;

        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(1, 6);
        else if (r < 88)
            return $urandom_range(7, 16);
        else if (r < 97)
            return $urandom_range(17, CAPACITY);
        else
            return $urandom_range(CAPACITY + 1, CAPACITY + 4);
    endfunction

    // offer one entry and hold it until the beat is taken; ends on a falling edge
    task automatic send_entry(logic [KEY_W-1:0] key, logic closes);
        in_valid   = 1'b1;
        entry_key  = key;
        last_entry = closes;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ranks.load_entry(key, closes);
        loaded++;
        @(negedge clk);
    endtask

    // sender gap burst between entries
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    task automatic send_set(int count, bit tie_heavy);
        for (int i = 0; i < count; i++)
        begin
            send_entry(pick_key(tie_heavy), i == count - 1);
            maybe_gap();
        end
        in_valid = 1'b0;
    endtask

    // all predicted beats out, then let the chain settle
    task automatic wait_idle();
        in_valid = 1'b0;
        while (ranks.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_tie_rule(bit later);
        cfg_valid = 1'b1;
        cfg_data  = later;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ranks.set_tie_rule(later);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int  phase;
        bit  later;

        ranks      = new(CAPACITY);
        calm       = 1'b0;
        hold_asks  = 0;
        loaded     = 0;
        in_valid   = 1'b0;
        entry_key  = '0;
        last_entry = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        rst_n      = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed sets ----
        write_tie_rule(1'b1);
        // one-entry set: the closing entry alone
        send_entry(KEY_MAX, 1'b1);
        // equal keys at both extremes, later entry wins ties
        send_entry('0, 1'b0);
        send_entry(KEY_MAX, 1'b0);
        send_entry(KEY_MAX, 1'b0);
        send_entry('0, 1'b0);
        send_entry(KEY_W'({(KEY_W+1)/2{2'b01}}), 1'b1);
        wait_idle();
        // same set with the earlier entry winning ties
        write_tie_rule(1'b0);
        send_entry('0, 1'b0);
        send_entry(KEY_MAX, 1'b0);
        send_entry(KEY_MAX, 1'b0);
        send_entry('0, 1'b0);
        send_entry(KEY_W'({(KEY_W+1)/2{2'b01}}), 1'b1);
        // an alternating bit pattern and a tied pair, loaded back to back
        send_entry(KEY_W'({(KEY_W+1)/2{2'b10}}), 1'b0);
        send_entry(KEY_W'(1), 1'b0);
        send_entry(KEY_W'(1), 1'b0);
        send_entry('0, 1'b1);
        in_valid = 1'b0;

        // ---- random phases, tie rule rewritten between them ----
        phase = 0;
        while (loaded < ITEM_TARGET)
        begin
            wait_idle();
            later = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
            write_tie_rule(later);
            calm = ($urandom_range(0, 3) == 0);
            case (phase)
                1:  send_set(CAPACITY, 1'b0);               // store filled exactly
                2:  send_set(CAPACITY + 2, 1'b1);           // entries dropped, last dropped too
                3:
                begin
                    // receiver holds off while the next set is already offered
                    hold_asks++;
                    send_set(6, 1'b0);
                    send_set(8, 1'b1);
                end
                default:
                    repeat ($urandom_range(3, 5))
                        send_set(pick_set_size(), $urandom_range(0, 2) == 0);
            endcase
            phase++;
        end

        // ---- final stretch with no idling at all ----
        wait_idle();
        write_tie_rule(1'($urandom_range(0, 1)));
        calm = 1'b1;
        repeat (4)
            send_set($urandom_range(1, 12), $urandom_range(0, 1));
        wait_idle();

        for (int i = 0; i < ranks.outstanding(); i++)
            ranks.note_fault();
        $display("run: %0d entries in %0d sets, %0d result beats checked",
                 loaded, ranks.sets_ranked, ranks.beats_checked);
        $display("run: %0d full and %0d overflowing sets; tie rule earlier/later %0d/%0d sets",
                 ranks.sets_full, ranks.sets_over, ranks.tie_sets[0], ranks.tie_sets[1]);
        if (ranks.faults == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
